/* src/shpd_pkg.sv */
// shared types, register indexes and helper functions for the shape hull point block
package shpd_pkg;

    localparam int WORD_WIDTH      = 32;
    localparam int WIDE_WIDTH      = 2 * WORD_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int SQRT_STEPS      = WORD_WIDTH;
    localparam int DIV_STEPS       = WORD_WIDTH;

    localparam logic [1:0] KIND_SPHERE    = 2'd0;
    localparam logic [1:0] KIND_CYLINDER  = 2'd1;
    localparam logic [1:0] KIND_ELLIPSOID = 2'd2;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_X   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_Y   = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RADIUS_Z   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CYL_LENGTH = 3'd4;

    typedef logic [2:0][WORD_WIDTH-1:0] vec3_t;
    typedef logic [2:0][WIDE_WIDTH-1:0] vec3w_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero_err;
        logic       axial;
    } side_t;

    function automatic logic [WORD_WIDTH-1:0] mag_of(input logic [WORD_WIDTH-1:0] v);
        return v[WORD_WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // left shift that brings the largest magnitude into [2^30, 2^31]
    function automatic logic [4:0] norm_shift(input logic [WORD_WIDTH-1:0] v);
        logic [4:0] sh;
        sh = 5'd0;
        for (int i = 0; i < WORD_WIDTH; i++)
        begin
            if (v[i])
                sh = (i >= WORD_WIDTH - 2) ? 5'd0 : 5'(WORD_WIDTH - 2 - i);
        end
        return sh;
    endfunction

endpackage

/* src/shape_hull_point_from_direction_top.sv */
// top level of the shape hull point block: normalize, square, root, scale and divide pipeline
//
// One word is accepted every clock cycle while the output side does not stall. Its core
// is a 32-stage square root, one result bit per stage, followed by three 32-stage restoring
// dividers, one quotient bit per stage, working side by side on x, y and z. A stall on the
// output holds the whole pipeline.
// Configuration registers are read live and must only be written while the block is empty.
module shape_hull_point_from_direction_top
    import shpd_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [WORD_WIDTH-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [WORD_WIDTH-1:0] dir_x,
    input  logic signed [WORD_WIDTH-1:0] dir_y,
    input  logic signed [WORD_WIDTH-1:0] dir_z,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [WORD_WIDTH-1:0] hit_x,
    output logic signed [WORD_WIDTH-1:0] hit_y,
    output logic signed [WORD_WIDTH-1:0] hit_z,
    output logic                       zero_error
);

    // configuration
    logic [1:0]            shape_kind_reg;
    logic [WORD_WIDTH-2:0] radius_x_reg;
    logic [WORD_WIDTH-2:0] radius_y_reg;
    logic [WORD_WIDTH-2:0] radius_z_reg;
    logic [WORD_WIDTH-1:0] cyl_length_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shape_kind_reg <= KIND_SPHERE;
            radius_x_reg   <= 31'd65536;
            radius_y_reg   <= 31'd65536;
            radius_z_reg   <= 31'd65536;
            cyl_length_reg <= 32'd131072;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_SHAPE_KIND: shape_kind_reg <= cfg_data[1:0];
                REG_RADIUS_X:   radius_x_reg   <= cfg_data[WORD_WIDTH-2:0];
                REG_RADIUS_Y:   radius_y_reg   <= cfg_data[WORD_WIDTH-2:0];
                REG_RADIUS_Z:   radius_z_reg   <= cfg_data[WORD_WIDTH-2:0];
                REG_CYL_LENGTH: cyl_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic is_cyl;
    logic is_ellip;
    assign is_cyl   = (shape_kind_reg == KIND_CYLINDER);
    assign is_ellip = (shape_kind_reg == KIND_ELLIPSOID);

    logic adv;
    logic out_valid_reg;
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // stage 1: magnitudes and signs
    logic       s1_valid_reg;
    vec3_t      s1_mag_reg;
    logic [2:0] s1_neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_mag_reg[0] <= mag_of(dir_x);
            s1_mag_reg[1] <= mag_of(dir_y);
            s1_mag_reg[2] <= mag_of(dir_z);
            s1_neg_reg    <= {dir_z[WORD_WIDTH-1], dir_y[WORD_WIDTH-1], dir_x[WORD_WIDTH-1]};
        end
    end

    // stage 2: largest magnitude, shift amount, special cases
    logic [WORD_WIDTH-1:0] big;
    side_t                 s2_side_next;
    logic                  s2_valid_reg;
    vec3_t                 s2_mag_reg;
    logic [4:0]            s2_sh_reg;
    side_t                 s2_side_reg;

    always_comb
    begin
        big = s1_mag_reg[0];
        if (s1_mag_reg[1] > big)
            big = s1_mag_reg[1];
        if (s1_mag_reg[2] > big)
            big = s1_mag_reg[2];
        s2_side_next.neg      = s1_neg_reg;
        s2_side_next.zero_err = !is_cyl && (big == '0);
        s2_side_next.axial    = is_cyl && (s1_mag_reg[0] == '0) && (s1_mag_reg[1] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_mag_reg  <= s1_mag_reg;
            s2_sh_reg   <= norm_shift(big);
            s2_side_reg <= s2_side_next;
        end
    end

    // stage 3: normalize
    logic  s3_valid_reg;
    vec3_t s3_mag_reg;
    side_t s3_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else if (adv)
            s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                s3_mag_reg[i] <= s2_mag_reg[i] << s2_sh_reg;
            s3_side_reg <= s2_side_reg;
        end
    end

    // stage 4: squares
    logic   s4_valid_reg;
    vec3_t  s4_mag_reg;
    vec3w_t s4_sq_reg;
    side_t  s4_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_valid_reg <= 1'b0;
        else if (adv)
            s4_valid_reg <= s3_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                s4_sq_reg[i] <= WIDE_WIDTH'(s3_mag_reg[i]) * WIDE_WIDTH'(s3_mag_reg[i]);
            s4_mag_reg  <= s3_mag_reg;
            s4_side_reg <= s3_side_reg;
        end
    end

    // square root pipeline, entry 0 holds the radicand
    logic                  sq_valid_reg [0:SQRT_STEPS];
    logic [WIDE_WIDTH-1:0] sq_v_reg     [0:SQRT_STEPS];
    logic [WIDE_WIDTH-1:0] sq_r_reg     [0:SQRT_STEPS];
    vec3_t                 sq_mag_reg   [0:SQRT_STEPS];
    side_t                 sq_side_reg  [0:SQRT_STEPS];
    logic [WIDE_WIDTH-1:0] sum_xy;

    assign sum_xy = s4_sq_reg[0] + s4_sq_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg[0] <= 1'b0;
        else if (adv)
            sq_valid_reg[0] <= s4_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_v_reg[0]    <= is_cyl ? sum_xy : sum_xy + s4_sq_reg[2];
            sq_r_reg[0]    <= '0;
            sq_mag_reg[0]  <= s4_mag_reg;
            sq_side_reg[0] <= s4_side_reg;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        localparam logic [WIDE_WIDTH-1:0] BIT = WIDE_WIDTH'(1) << (2 * (SQRT_STEPS - 1 - k));
        logic [WIDE_WIDTH:0] trial;
        logic                take;

        assign trial = {1'b0, sq_r_reg[k]} + {1'b0, BIT};
        assign take  = ({1'b0, sq_v_reg[k]} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                sq_valid_reg[k+1] <= 1'b0;
            else if (adv)
                sq_valid_reg[k+1] <= sq_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_v_reg[k+1]    <= take ? sq_v_reg[k] - trial[WIDE_WIDTH-1:0] : sq_v_reg[k];
                sq_r_reg[k+1]    <= take ? (sq_r_reg[k] >> 1) + BIT : sq_r_reg[k] >> 1;
                sq_mag_reg[k+1]  <= sq_mag_reg[k];
                sq_side_reg[k+1] <= sq_side_reg[k];
            end
        end
    end

    // cap test products
    logic [WORD_WIDTH-1:0] root;
    logic                  m1_valid_reg;
    logic [WIDE_WIDTH-1:0] m1_capl_reg;
    logic [WIDE_WIDTH-1:0] m1_capr_reg;
    logic [WORD_WIDTH-1:0] m1_s_reg;
    vec3_t                 m1_mag_reg;
    side_t                 m1_side_reg;

    assign root = sq_r_reg[SQRT_STEPS][WORD_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (adv)
            m1_valid_reg <= sq_valid_reg[SQRT_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_capl_reg <= WIDE_WIDTH'(radius_x_reg) * WIDE_WIDTH'(sq_mag_reg[SQRT_STEPS][2]);
            m1_capr_reg <= WIDE_WIDTH'(cyl_length_reg) * WIDE_WIDTH'(root);
            m1_s_reg    <= root;
            m1_mag_reg  <= sq_mag_reg[SQRT_STEPS];
            m1_side_reg <= sq_side_reg[SQRT_STEPS];
        end
    end

    // cap decision
    logic                  m2_valid_reg;
    logic                  m2_cap_reg;
    logic [WORD_WIDTH-1:0] m2_s_reg;
    vec3_t                 m2_mag_reg;
    side_t                 m2_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else if (adv)
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m2_cap_reg  <= is_cyl && !m1_side_reg.axial &&
                           ({m1_capl_reg, 1'b0} > {1'b0, m1_capr_reg});
            m2_s_reg    <= m1_s_reg;
            m2_mag_reg  <= m1_mag_reg;
            m2_side_reg <= m1_side_reg;
        end
    end

    // dividend and divisor, entry 0 of the divider pipeline
    logic                  dv_valid_reg [0:DIV_STEPS];
    vec3w_t                dv_rem_reg   [0:DIV_STEPS];
    vec3_t                 dv_q_reg     [0:DIV_STEPS];
    logic [WORD_WIDTH:0]   dv_den_reg   [0:DIV_STEPS];
    side_t                 dv_side_reg  [0:DIV_STEPS];
    vec3_t                 factor;

    always_comb
    begin
        if (m2_cap_reg)
        begin
            factor[0] = cyl_length_reg;
            factor[1] = cyl_length_reg;
            factor[2] = cyl_length_reg;
        end
        else if (is_ellip)
        begin
            factor[0] = {1'b0, radius_x_reg};
            factor[1] = {1'b0, radius_y_reg};
            factor[2] = {1'b0, radius_z_reg};
        end
        else
        begin
            factor[0] = {1'b0, radius_x_reg};
            factor[1] = {1'b0, radius_x_reg};
            factor[2] = {1'b0, radius_x_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_valid_reg[0] <= 1'b0;
        else if (adv)
            dv_valid_reg[0] <= m2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
                dv_rem_reg[0][i] <= WIDE_WIDTH'(m2_mag_reg[i]) * WIDE_WIDTH'(factor[i]);
            dv_q_reg[0]    <= '0;
            dv_den_reg[0]  <= m2_cap_reg ? {m2_mag_reg[2], 1'b0} : {1'b0, m2_s_reg};
            dv_side_reg[0] <= m2_side_reg;
        end
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [WIDE_WIDTH:0] trial;
        vec3w_t              rem_next;
        vec3_t               q_next;

        assign trial = {{(WIDE_WIDTH - WORD_WIDTH){1'b0}}, dv_den_reg[k]} << SH;

        always_comb
        begin
            rem_next = dv_rem_reg[k];
            q_next   = dv_q_reg[k];
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, dv_rem_reg[k][i]} >= trial)
                begin
                    rem_next[i]   = dv_rem_reg[k][i] - trial[WIDE_WIDTH-1:0];
                    q_next[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k+1]  <= rem_next;
                dv_q_reg[k+1]    <= q_next;
                dv_den_reg[k+1]  <= dv_den_reg[k];
                dv_side_reg[k+1] <= dv_side_reg[k];
            end
        end
    end

    // output word: special cases and signs
    side_t fin_side;
    vec3_t fin_mag;
    vec3_t fin_val;
    vec3_t hit_reg;
    logic  zero_error_reg;

    assign fin_side = dv_side_reg[DIV_STEPS];

    always_comb
    begin
        fin_mag = dv_q_reg[DIV_STEPS];
        if (fin_side.zero_err)
            fin_mag = '0;
        else if (fin_side.axial)
        begin
            fin_mag[0] = '0;
            fin_mag[1] = '0;
            fin_mag[2] = cyl_length_reg >> 1;
        end
        for (int i = 0; i < 3; i++)
            fin_val[i] = fin_side.neg[i] ? (~fin_mag[i] + 1'b1) : fin_mag[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= dv_valid_reg[DIV_STEPS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg        <= fin_val;
            zero_error_reg <= fin_side.zero_err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign hit_x      = hit_reg[0];
    assign hit_y      = hit_reg[1];
    assign hit_z      = hit_reg[2];
    assign zero_error = zero_error_reg;

endmodule
